FILE: src/stder_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stder_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int PIX_BITS   = 8;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int GRAD_BITS  = 11;
   localparam int WREG_BITS  = 11;
   localparam int HREG_BITS  = 13;
   localparam int CSR_BITS   = 13;
   localparam int NUM_KINDS  = 3;

   localparam logic [WREG_BITS-1:0] WIDTH_RESET  = WREG_BITS'(640);
   localparam logic [HREG_BITS-1:0] HEIGHT_RESET = HREG_BITS'(480);
   localparam logic [WREG_BITS-1:0] WIDTH_MAX    = WREG_BITS'(MAX_WIDTH);
   localparam logic [HREG_BITS-1:0] HEIGHT_MAX   = HREG_BITS'(MAX_HEIGHT);

   // configuration register indexes
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // result kinds, as bit positions of a result mask, in emission order
   localparam int RES_CUBE     = 0;
   localparam int RES_LAST_COL = 1;
   localparam int RES_LAST_ROW = 2;

   typedef logic [NUM_KINDS-1:0] mask_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic [PIX_BITS-1:0] pixel_first;
      logic [PIX_BITS-1:0] pixel_second;
      mask_type            mask;
   } item_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]         row;
      logic [ROW_BITS-1:0]         row_m1;
      logic [COL_BITS-1:0]         col;
      logic [COL_BITS-1:0]         col_m1;
      logic signed [GRAD_BITS-1:0] grad_x;
      logic signed [GRAD_BITS-1:0] grad_y;
      logic signed [GRAD_BITS-1:0] grad_t;
      mask_type                    mask;
   } bundle_type;

endpackage

`default_nettype wire

FILE: src/spatiotemporal_derivatives.sv
`timescale 1ns / 1ps
`default_nettype none
// A result passes the gradient stage register and the emitter register on its way to rsp.
// Throughput: one pixel pair per cycle while rsp accepts results; the result
// port moves one result per cycle, so an input that yields more than one result
// (on the last column or last row) holds the input side until all are sent.
// Reset: frame 640 x 480, position at row 0 column 0, pipeline empty.
// The line memory is not cleared; each row is written before the next reads it.

module spatiotemporal_derivatives (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [7:0] pixel_first, [15:8] pixel_second
   input  wire logic [15:0]                       req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [11:0] out_row, [21:12] out_col, [32:22] grad_x, [43:33] grad_y,
   // [54:44] grad_t, [55] zero
   output logic [55:0]                            rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_we,
   input  wire logic                              csr_index,
   input  wire logic [stder_pkg::CSR_BITS-1:0]    csr_wdata
);

   localparam int RB = stder_pkg::ROW_BITS;
   localparam int CB = stder_pkg::COL_BITS;
   localparam int PB = stder_pkg::PIX_BITS;

   logic [stder_pkg::WREG_BITS-1:0] frame_width_ff, frame_width_in;
   logic [stder_pkg::HREG_BITS-1:0] frame_height_ff, frame_height_in;
   logic [RB-1:0]                   row_ff, row_in;
   logic [CB-1:0]                   col_ff, col_in;

   logic [stder_pkg::WREG_BITS-1:0] width_eff, width_m1;
   logic [stder_pkg::HREG_BITS-1:0] height_eff, height_m1;
   logic                            col_is_last, row_is_last;
   logic                            accept;

   stder_pkg::item_type   item;
   stder_pkg::bundle_type bundle;
   logic                  bundle_valid, bundle_ready;
   logic [2*PB-1:0]       up_pair;

   always_comb begin
      if (frame_width_ff == '0) width_eff = stder_pkg::WREG_BITS'(1);
      else if (frame_width_ff > stder_pkg::WIDTH_MAX) width_eff = stder_pkg::WIDTH_MAX;
      else width_eff = frame_width_ff;
      if (frame_height_ff == '0) height_eff = stder_pkg::HREG_BITS'(1);
      else if (frame_height_ff > stder_pkg::HEIGHT_MAX) height_eff = stder_pkg::HEIGHT_MAX;
      else height_eff = frame_height_ff;
   end

   assign width_m1    = width_eff - 1'b1;
   assign height_m1   = height_eff - 1'b1;
   assign col_is_last = (col_ff == width_m1[CB-1:0]);
   assign row_is_last = (row_ff == height_m1[RB-1:0]);
   assign accept      = req_tvalid && req_tready;

   always_comb begin
      item.row                          = row_ff;
      item.col                          = col_ff;
      item.pixel_first                  = req_tdata[PB-1:0];
      item.pixel_second                 = req_tdata[2*PB-1:PB];
      item.mask                         = '0;
      item.mask[stder_pkg::RES_CUBE]     = (row_ff != '0) && (col_ff != '0);
      item.mask[stder_pkg::RES_LAST_COL] = (row_ff != '0) && col_is_last;
      item.mask[stder_pkg::RES_LAST_ROW] = row_is_last;
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      if (accept) begin
         if (col_is_last) begin
            col_in = '0;
            row_in = row_is_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      // a register write restarts the frame
      if (csr_we) begin
         row_in = '0;
         col_in = '0;
         unique case (csr_index)
            stder_pkg::REG_FRAME_WIDTH:  frame_width_in  = csr_wdata[stder_pkg::WREG_BITS-1:0];
            stder_pkg::REG_FRAME_HEIGHT: frame_height_in = csr_wdata[stder_pkg::HREG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= stder_pkg::WIDTH_RESET;
         frame_height_ff <= stder_pkg::HEIGHT_RESET;
         row_ff          <= '0;
         col_ff          <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
      end
   end

   stder_line_buffer u_line_buffer (
      .clock  (clock),
      .enable (accept),
      .addr   (col_ff),
      .wdata  (req_tdata[2*PB-1:0]),
      .rdata  (up_pair)
   );

   stder_gradient u_gradient (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (item),
      .up_first   (up_pair[PB-1:0]),
      .up_second  (up_pair[2*PB-1:PB]),
      .out_valid  (bundle_valid),
      .out_ready  (bundle_ready),
      .out_bundle (bundle)
   );

   stder_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (bundle_valid),
      .in_ready   (bundle_ready),
      .in_bundle  (bundle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: src/stder_line_buffer.sv
`timescale 1ns / 1ps
`default_nettype none

module stder_line_buffer (
   input  wire logic                                clock,
   input  wire logic                                enable,
   input  wire logic [stder_pkg::COL_BITS-1:0]      addr,
   input  wire logic [2*stder_pkg::PIX_BITS-1:0]    wdata,
   output logic      [2*stder_pkg::PIX_BITS-1:0]    rdata
);

   localparam int DEPTH = stder_pkg::MAX_WIDTH;

   logic [2*stder_pkg::PIX_BITS-1:0] mem [DEPTH];
   logic [2*stder_pkg::PIX_BITS-1:0] rdata_ff;

   // read-first: the read returns the previous row's pixel pair at this column
   always_ff @(posedge clock) begin
      if (enable) begin
         rdata_ff  <= mem[addr];
         mem[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: src/stder_gradient.sv
`timescale 1ns / 1ps
`default_nettype none

module stder_gradient (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   output logic                                  in_ready,
   input  wire stder_pkg::item_type              in_item,
   input  wire logic [stder_pkg::PIX_BITS-1:0]   up_first,
   input  wire logic [stder_pkg::PIX_BITS-1:0]   up_second,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output stder_pkg::bundle_type                 out_bundle
);

   localparam int PB = stder_pkg::PIX_BITS;
   localparam int GB = stder_pkg::GRAD_BITS;

   logic                 valid_ff, valid_in;
   stder_pkg::item_type  item_ff, item_in;
   logic [PB-1:0]        left_first_ff, left_first_in;
   logic [PB-1:0]        left_second_ff, left_second_in;
   logic [PB-1:0]        upleft_first_ff, upleft_first_in;
   logic [PB-1:0]        upleft_second_ff, upleft_second_in;
   logic                 advance;
   logic                 take;

   logic signed [GB-1:0] a_s, b_s, ua_s, ub_s, la_s, lb_s, ula_s, ulb_s;
   logic signed [GB-1:0] cur_s, up_s, lf_s, ul_s;

   assign advance  = valid_ff && ((item_ff.mask == '0) || out_ready);
   assign in_ready = !valid_ff || advance;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in         = valid_ff;
      item_in          = item_ff;
      left_first_in    = left_first_ff;
      left_second_in   = left_second_ff;
      upleft_first_in  = upleft_first_ff;
      upleft_second_in = upleft_second_ff;
      if (advance) begin
         valid_in         = 1'b0;
         left_first_in    = item_ff.pixel_first;
         left_second_in   = item_ff.pixel_second;
         upleft_first_in  = up_first;
         upleft_second_in = up_second;
      end
      if (take) begin
         valid_in = 1'b1;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff         <= 1'b0;
         left_first_ff    <= '0;
         left_second_ff   <= '0;
         upleft_first_ff  <= '0;
         upleft_second_ff <= '0;
      end else begin
         valid_ff         <= valid_in;
         left_first_ff    <= left_first_in;
         left_second_ff   <= left_second_in;
         upleft_first_ff  <= upleft_first_in;
         upleft_second_ff <= upleft_second_in;
      end
      item_ff <= item_in;
   end

   // the sums fit in GRAD_BITS, so plain wrapping arithmetic is exact
   assign a_s   = signed'(GB'(item_ff.pixel_first));
   assign b_s   = signed'(GB'(item_ff.pixel_second));
   assign ua_s  = signed'(GB'(up_first));
   assign ub_s  = signed'(GB'(up_second));
   assign la_s  = signed'(GB'(left_first_ff));
   assign lb_s  = signed'(GB'(left_second_ff));
   assign ula_s = signed'(GB'(upleft_first_ff));
   assign ulb_s = signed'(GB'(upleft_second_ff));

   assign cur_s = a_s + b_s;
   assign up_s  = ua_s + ub_s;
   assign lf_s  = la_s + lb_s;
   assign ul_s  = ula_s + ulb_s;

   always_comb begin
      out_bundle.row    = item_ff.row;
      out_bundle.row_m1 = item_ff.row - 1'b1;
      out_bundle.col    = item_ff.col;
      out_bundle.col_m1 = item_ff.col - 1'b1;
      out_bundle.grad_x = up_s + cur_s - ul_s - lf_s;
      out_bundle.grad_y = lf_s + cur_s - ul_s - up_s;
      out_bundle.grad_t = (b_s + ub_s + lb_s + ulb_s) - (a_s + ua_s + la_s + ula_s);
      out_bundle.mask   = item_ff.mask;
   end

   // drop items that cause no result here
   assign out_valid = valid_ff && (item_ff.mask != '0);

endmodule

`default_nettype wire

FILE: src/stder_emitter.sv
`timescale 1ns / 1ps
`default_nettype none

module stder_emitter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire stder_pkg::bundle_type               in_bundle,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [55:0]                              rsp_tdata,
   output logic                                     rsp_tlast
);

   localparam int GB = stder_pkg::GRAD_BITS;

   logic                   valid_ff, valid_in;
   stder_pkg::bundle_type  bundle_ff, bundle_in;
   stder_pkg::mask_type    mask_ff, mask_in;
   stder_pkg::mask_type    lowest;
   stder_pkg::mask_type    remaining;
   logic                   last;
   logic                   xfer;
   logic                   take;

   logic [stder_pkg::ROW_BITS-1:0] row_out;
   logic [stder_pkg::COL_BITS-1:0] col_out;
   logic signed [GB-1:0]           gx_out, gy_out, gt_out;

   assign lowest    = mask_ff & (~mask_ff + 1'b1);
   assign remaining = mask_ff & ~lowest;
   assign last      = (remaining == '0);
   assign xfer      = valid_ff && rsp_tready;
   assign in_ready  = !valid_ff || (rsp_tready && last);
   assign take      = in_valid && in_ready;

   always_comb begin
      valid_in  = valid_ff;
      bundle_in = bundle_ff;
      mask_in   = mask_ff;
      if (xfer) begin
         mask_in = remaining;
         if (last) valid_in = 1'b0;
      end
      if (take) begin
         valid_in  = 1'b1;
         bundle_in = in_bundle;
         mask_in   = in_bundle.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mask_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         mask_ff  <= mask_in;
      end
      bundle_ff <= bundle_in;
   end

   always_comb begin
      gx_out = '0;
      gy_out = '0;
      gt_out = '0;
      if (lowest[stder_pkg::RES_CUBE]) begin
         row_out = bundle_ff.row_m1;
         col_out = bundle_ff.col_m1;
         gx_out  = bundle_ff.grad_x;
         gy_out  = bundle_ff.grad_y;
         gt_out  = bundle_ff.grad_t;
      end else if (lowest[stder_pkg::RES_LAST_COL]) begin
         row_out = bundle_ff.row_m1;
         col_out = bundle_ff.col;
      end else begin
         row_out = bundle_ff.row;
         col_out = bundle_ff.col;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last;
   assign rsp_tdata  = {1'b0, gt_out, gy_out, gx_out, col_out, row_out};

`ifndef NO_ASSERTIONS
   a_valid_has_result : assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (mask_ff != '0))
      else $error("pending bundle has no result left");

   a_mask_shrinks : assert property (@(posedge clock) disable iff (reset)
      (xfer && !last) |=> (valid_ff &&
         ($countones(mask_ff) == $countones($past(mask_ff)) - 1)))
      else $error("result mask did not drop exactly one result");

   a_stall_holds_mask : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |=> (valid_ff && $stable(mask_ff)))
      else $error("result mask changed during stall");
`endif

endmodule

`default_nettype wire
